// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fvc_pkg.sv =====
`timescale 1ns / 1ps
package fvc_pkg;

   localparam int FRAC_BITS     = 12;
   localparam int WHEEL_ENTRIES = 55;
   localparam int CORDIC_STEPS  = 16;
   localparam int PRE_SHIFT     = 14;
   localparam int TURN_BITS     = 24;
   localparam int INV_GAIN      = 39797;
   localparam int RAD_SHIFT     = 16 + FRAC_BITS - 2;

   localparam logic [24:0] QUARTER_TURN = 25'd1 << (TURN_BITS - 2);
   localparam logic [24:0] HALF_TURN    = 25'd1 << (TURN_BITS - 1);
   localparam logic [24:0] FULL_TURN    = 25'd1 << TURN_BITS;
   localparam logic [31:0] WHITE_LEVEL  = 32'd255 << TURN_BITS;
   localparam logic [31:0] UNIT_RADIUS  = 32'd65536;

   localparam logic [24:0] ATAN_UNITS [CORDIC_STEPS] = '{
      25'd2097152, 25'd1238021, 25'd654136, 25'd332050, 25'd166669, 25'd83416,
      25'd41718, 25'd20860, 25'd10430, 25'd5215, 25'd2608, 25'd1304, 25'd652,
      25'd326, 25'd163, 25'd81
   };

   // sign and zero flags of the input vector, carried down the pipeline
   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } fvc_flags_type;

   // hue wheel entry as {red, green, blue}
   function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
      logic [23:0] rgb;
      case (k)
         6'd0:  rgb = {8'd255, 8'd0,   8'd0};
         6'd1:  rgb = {8'd255, 8'd17,  8'd0};
         6'd2:  rgb = {8'd255, 8'd34,  8'd0};
         6'd3:  rgb = {8'd255, 8'd51,  8'd0};
         6'd4:  rgb = {8'd255, 8'd68,  8'd0};
         6'd5:  rgb = {8'd255, 8'd85,  8'd0};
         6'd6:  rgb = {8'd255, 8'd102, 8'd0};
         6'd7:  rgb = {8'd255, 8'd119, 8'd0};
         6'd8:  rgb = {8'd255, 8'd136, 8'd0};
         6'd9:  rgb = {8'd255, 8'd153, 8'd0};
         6'd10: rgb = {8'd255, 8'd170, 8'd0};
         6'd11: rgb = {8'd255, 8'd187, 8'd0};
         6'd12: rgb = {8'd255, 8'd204, 8'd0};
         6'd13: rgb = {8'd255, 8'd221, 8'd0};
         6'd14: rgb = {8'd255, 8'd238, 8'd0};
         6'd15: rgb = {8'd255, 8'd255, 8'd0};
         6'd16: rgb = {8'd213, 8'd255, 8'd0};
         6'd17: rgb = {8'd170, 8'd255, 8'd0};
         6'd18: rgb = {8'd128, 8'd255, 8'd0};
         6'd19: rgb = {8'd85,  8'd255, 8'd0};
         6'd20: rgb = {8'd43,  8'd255, 8'd0};
         6'd21: rgb = {8'd0,   8'd255, 8'd0};
         6'd22: rgb = {8'd0,   8'd255, 8'd63};
         6'd23: rgb = {8'd0,   8'd255, 8'd127};
         6'd24: rgb = {8'd0,   8'd255, 8'd191};
         6'd25: rgb = {8'd0,   8'd255, 8'd255};
         6'd26: rgb = {8'd0,   8'd232, 8'd255};
         6'd27: rgb = {8'd0,   8'd209, 8'd255};
         6'd28: rgb = {8'd0,   8'd186, 8'd255};
         6'd29: rgb = {8'd0,   8'd163, 8'd255};
         6'd30: rgb = {8'd0,   8'd140, 8'd255};
         6'd31: rgb = {8'd0,   8'd116, 8'd255};
         6'd32: rgb = {8'd0,   8'd93,  8'd255};
         6'd33: rgb = {8'd0,   8'd70,  8'd255};
         6'd34: rgb = {8'd0,   8'd47,  8'd255};
         6'd35: rgb = {8'd0,   8'd24,  8'd255};
         6'd36: rgb = {8'd0,   8'd0,   8'd255};
         6'd37: rgb = {8'd19,  8'd0,   8'd255};
         6'd38: rgb = {8'd39,  8'd0,   8'd255};
         6'd39: rgb = {8'd58,  8'd0,   8'd255};
         6'd40: rgb = {8'd78,  8'd0,   8'd255};
         6'd41: rgb = {8'd98,  8'd0,   8'd255};
         6'd42: rgb = {8'd117, 8'd0,   8'd255};
         6'd43: rgb = {8'd137, 8'd0,   8'd255};
         6'd44: rgb = {8'd156, 8'd0,   8'd255};
         6'd45: rgb = {8'd176, 8'd0,   8'd255};
         6'd46: rgb = {8'd196, 8'd0,   8'd255};
         6'd47: rgb = {8'd215, 8'd0,   8'd255};
         6'd48: rgb = {8'd235, 8'd0,   8'd255};
         6'd49: rgb = {8'd255, 8'd0,   8'd255};
         6'd50: rgb = {8'd255, 8'd0,   8'd213};
         6'd51: rgb = {8'd255, 8'd0,   8'd170};
         6'd52: rgb = {8'd255, 8'd0,   8'd128};
         6'd53: rgb = {8'd255, 8'd0,   8'd85};
         default: rgb = {8'd255, 8'd0, 8'd43};
      endcase
      return rgb;
   endfunction

endpackage

// ===== design/fvc_cordic.sv =====
`timescale 1ns / 1ps
module fvc_cordic import fvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic signed [31:0]  in_cx,
   input  logic signed [31:0]  in_cy,
   input  fvc_flags_type       in_flags,
   output logic                out_valid,
   output logic signed [31:0]  out_cx,
   output logic signed [24:0]  out_z,
   output fvc_flags_type       out_flags
);

   logic                vld_ff   [CORDIC_STEPS];
   logic signed [31:0]  cx_ff    [CORDIC_STEPS];
   logic signed [31:0]  cy_ff    [CORDIC_STEPS];
   logic signed [24:0]  z_ff     [CORDIC_STEPS];
   fvc_flags_type       flags_ff [CORDIC_STEPS];

   // one vectoring iteration per register stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic                src_vld;
      logic signed [31:0]  src_cx;
      logic signed [31:0]  src_cy;
      logic signed [24:0]  src_z;
      fvc_flags_type       src_flags;
      logic signed [31:0]  cx_in;
      logic signed [31:0]  cy_in;
      logic signed [24:0]  z_in;

      if (i == 0) begin : g_first
         assign src_vld   = in_valid;
         assign src_cx    = in_cx;
         assign src_cy    = in_cy;
         assign src_z     = '0;
         assign src_flags = in_flags;
      end else begin : g_next
         assign src_vld   = vld_ff[i-1];
         assign src_cx    = cx_ff[i-1];
         assign src_cy    = cy_ff[i-1];
         assign src_z     = z_ff[i-1];
         assign src_flags = flags_ff[i-1];
      end

      // rotate toward the x axis, shifts floor toward minus infinity
      always_comb begin
         if (src_cy > 0) begin
            cx_in = src_cx + (src_cy >>> i);
            cy_in = src_cy - (src_cx >>> i);
            z_in  = src_z + $signed(ATAN_UNITS[i]);
         end else begin
            cx_in = src_cx - (src_cy >>> i);
            cy_in = src_cy + (src_cx >>> i);
            z_in  = src_z - $signed(ATAN_UNITS[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (enable) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            cx_ff[i]    <= cx_in;
            cy_ff[i]    <= cy_in;
            z_ff[i]     <= z_in;
            flags_ff[i] <= src_flags;
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_cx    = cx_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_flags = flags_ff[CORDIC_STEPS-1];

endmodule

// ===== design/fvc_color.sv =====
`timescale 1ns / 1ps
module fvc_color import fvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic signed [31:0]  in_cx,
   input  logic signed [24:0]  in_z,
   input  fvc_flags_type       in_flags,
   output logic                out_valid,
   output logic [7:0]          out_red,
   output logic [7:0]          out_green,
   output logic [7:0]          out_blue
);

   logic [4:0] vld_ff;

   // stage a: angle on the full circle, magnitude gain product
   logic [24:0] z_clamp;
   logic [24:0] alpha;
   logic [24:0] ang_full;
   logic [23:0] ang_in;
   logic [46:0] mag_in;
   logic [23:0] ang_ff;
   logic [46:0] mag_ff;

   always_comb begin
      if (in_z < 0) begin
         z_clamp = '0;
      end else if (in_z > $signed(QUARTER_TURN)) begin
         z_clamp = QUARTER_TURN;
      end else begin
         z_clamp = in_z;
      end
      if (in_flags.y_zero) begin
         alpha = '0;
      end else if (in_flags.x_zero) begin
         alpha = QUARTER_TURN;
      end else begin
         alpha = z_clamp;
      end
      if (in_flags.x_zero && in_flags.y_zero) begin
         ang_full = '0;
      end else if (!in_flags.x_neg && !in_flags.y_neg) begin
         ang_full = alpha;
      end else if (in_flags.x_neg && !in_flags.y_neg) begin
         ang_full = HALF_TURN - alpha;
      end else if (in_flags.x_neg) begin
         ang_full = HALF_TURN + alpha;
      end else begin
         ang_full = FULL_TURN - alpha;
      end
      ang_in = ang_full[23:0];
      mag_in = (in_cx > 0) ? ({16'd0, in_cx[30:0]} * 47'(INV_GAIN)) : '0;
   end

   // stage b: wheel position and radius
   logic [29:0] pos;
   logic [31:0] rad_in;
   logic [5:0]  k0_in;
   logic [23:0] f_in;
   logic [5:0]  k0_ff;
   logic [23:0] f_ff;
   logic [31:0] rad_ff;

   always_comb begin
      pos    = {6'd0, ang_ff} * 30'(WHEEL_ENTRIES - 1);
      k0_in  = (pos[29:24] >= 6'(WHEEL_ENTRIES)) ? 6'(WHEEL_ENTRIES - 1) : pos[29:24];
      f_in   = pos[23:0];
      rad_in = 32'(mag_ff >> RAD_SHIFT);
   end

   // stage c: wheel lookup and interpolation products
   logic [5:0]  k1;
   logic [23:0] rgb0;
   logic [23:0] rgb1;
   logic [24:0] w0;
   logic [32:0] p0_in [3];
   logic [32:0] p1_in [3];
   logic [32:0] p0_ff [3];
   logic [32:0] p1_ff [3];
   logic [31:0] rad_c_ff;

   always_comb begin
      k1   = (k0_ff == 6'(WHEEL_ENTRIES - 1)) ? 6'd0 : k0_ff + 6'd1;
      rgb0 = wheel_rgb(k0_ff);
      rgb1 = wheel_rgb(k1);
      w0   = FULL_TURN - {1'b0, f_ff};
      for (int ch = 0; ch < 3; ch++) begin
         p0_in[ch] = {8'd0, w0} * {25'd0, rgb0[23 - 8*ch -: 8]};
         p1_in[ch] = {9'd0, f_ff} * {25'd0, rgb1[23 - 8*ch -: 8]};
      end
   end

   // stage d: blend sum, saturate, desaturation product
   logic [33:0] sum [3];
   logic [31:0] c_in [3];
   logic [48:0] dprod_in [3];
   logic        unit_in;
   logic [31:0] c_ff [3];
   logic [48:0] dprod_ff [3];
   logic        unit_ff;

   always_comb begin
      unit_in = (rad_c_ff <= UNIT_RADIUS);
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch]      = {1'b0, p0_ff[ch]} + {1'b0, p1_ff[ch]};
         c_in[ch]     = (sum[ch] > {2'd0, WHITE_LEVEL}) ? WHITE_LEVEL : sum[ch][31:0];
         dprod_in[ch] = {32'd0, rad_c_ff[16:0]} * {17'd0, WHITE_LEVEL - c_in[ch]};
      end
   end

   // stage e: output bytes
   logic [31:0] lite [3];
   logic [33:0] dark [3];
   logic [7:0]  byte_in [3];
   logic [7:0]  byte_ff [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         lite[ch] = WHITE_LEVEL - dprod_ff[ch][47:16];
         dark[ch] = {2'd0, c_ff[ch]} + {1'b0, c_ff[ch], 1'b0};
         byte_in[ch] = unit_ff ? lite[ch][31:24] : dark[ch][33:26];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ang_ff   <= ang_in;
         mag_ff   <= mag_in;
         k0_ff    <= k0_in;
         f_ff     <= f_in;
         rad_ff   <= rad_in;
         rad_c_ff <= rad_ff;
         unit_ff  <= unit_in;
         for (int ch = 0; ch < 3; ch++) begin
            p0_ff[ch]    <= p0_in[ch];
            p1_ff[ch]    <= p1_in[ch];
            c_ff[ch]     <= c_in[ch];
            dprod_ff[ch] <= dprod_in[ch];
            byte_ff[ch]  <= byte_in[ch];
         end
      end
   end

   assign out_valid = vld_ff[4];
   assign out_red   = byte_ff[0];
   assign out_green = byte_ff[1];
   assign out_blue  = byte_ff[2];

endmodule

// ===== design/flow_vector_to_color.sv =====
`timescale 1ns / 1ps
// path: an accepted transaction goes through the input register, cordic and color pipelines to rsp_
// throughput: one transaction per cycle; the 16-stage cordic pipeline and
// the 5-stage color pipeline advance together and freeze while a result waits
// reset: synchronous, active high, clears all pipeline valid bits
module flow_vector_to_color import fvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_flow_x,
   input  logic signed [15:0] req_flow_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);

   logic               enable;
   logic               vld_ff;
   logic signed [31:0] cx_ff;
   logic signed [31:0] cy_ff;
   fvc_flags_type      flags_ff;
   logic [16:0]        ax;
   logic [16:0]        ay;
   fvc_flags_type      flags_in;
   logic               cor_valid;
   logic signed [31:0] cor_cx;
   logic signed [24:0] cor_z;
   fvc_flags_type      cor_flags;

   // whole pipeline moves unless the output holds an untaken result
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // input stage: magnitudes pre-shifted, quadrant flags
   always_comb begin
      ax = req_flow_x[15] ? 17'(-{req_flow_x[15], req_flow_x}) : {1'b0, req_flow_x};
      ay = req_flow_y[15] ? 17'(-{req_flow_y[15], req_flow_y}) : {1'b0, req_flow_y};
      flags_in.x_neg  = req_flow_x[15];
      flags_in.y_neg  = req_flow_y[15];
      flags_in.x_zero = (req_flow_x == 16'sd0);
      flags_in.y_zero = (req_flow_y == 16'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cx_ff    <= $signed({1'b0, ax, 14'd0});
         cy_ff    <= $signed({1'b0, ay, 14'd0});
         flags_ff <= flags_in;
      end
   end

   fvc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (vld_ff),
      .in_cx     (cx_ff),
      .in_cy     (cy_ff),
      .in_flags  (flags_ff),
      .out_valid (cor_valid),
      .out_cx    (cor_cx),
      .out_z     (cor_z),
      .out_flags (cor_flags)
   );

   fvc_color u_color (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (cor_valid),
      .in_cx     (cor_cx),
      .in_z      (cor_z),
      .in_flags  (cor_flags),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

// ===== design/fvc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fvc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue
);

   logic        rsp_stall;
   logic [23:0] rsp_rgb;

   // result offered but not taken this cycle
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_rgb   = {rsp_red, rsp_green, rsp_blue};

   // stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "rsp dropped")
   // stalled result keeps its color
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_rgb), "rsp changed")
   // input is taken exactly when the pipeline advances
   `ASSERT_CLK(a_ready_rule, clock, reset, req_ready == !rsp_stall, "ready mismatch")
   // reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "valid after reset")

endmodule

bind flow_vector_to_color fvc_checker u_fvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);
